// File: hdl/accel_pitch_tilt_detector_assert.svh
// Assertion macros for the pitch-tilt detector controller.
// Each macro expects clk and arst_n to be visible in the module that uses it.
`ifndef ACCEL_PITCH_TILT_DETECTOR_ASSERT_SVH
`define ACCEL_PITCH_TILT_DETECTOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define APT_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define APT_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/apt_pkg.sv
`default_nettype none

package apt_pkg;

	// Field and datapath widths.
	localparam int unsigned ACC_W        = 16;
	localparam int unsigned ANGLE_W      = 17;
	localparam int unsigned ZONE_W       = 2;
	localparam int unsigned PITCH_W      = 16;
	localparam int unsigned SQ_W         = 32;
	localparam int unsigned ROOT_W       = 32;
	localparam int unsigned REM_W        = 36;
	localparam int unsigned VEC_W        = 35;
	localparam int unsigned ZACC_W       = 25;
	localparam int unsigned FRAC_W       = 16;
	localparam int unsigned CNT_W        = 5;
	localparam int unsigned ATAN_ENTRIES = 24;
	localparam int unsigned ROOT_STEPS   = 32;
	localparam int unsigned DATA_W       = 32;
	localparam int unsigned ADDR_W       = 3;

	// Pitch is clamped to +/-90 degrees, degrees times 256.
	localparam logic signed [PITCH_W-1:0] PITCH_LIMIT = 16'sd23040;

	// Threshold reset values: 45 and -30 degrees, times 256.
	localparam logic signed [ANGLE_W-1:0] UPPER_RESET = 17'sd11520;
	localparam logic signed [ANGLE_W-1:0] LOWER_RESET = -17'sd7680;

	// Request kinds.
	localparam logic REQ_CAL  = 1'b0;
	localparam logic REQ_MEAS = 1'b1;

	// Register index, taken from address bit 2.
	localparam logic REG_UPPER = 1'b0;
	localparam logic REG_LOWER = 1'b1;

	typedef enum logic [ZONE_W-1:0] {
		ZONE_LEVEL = 2'd0,
		ZONE_UP    = 2'd1,
		ZONE_DOWN  = 2'd2
	} zone_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             load;
		logic             sq_y;
		logic             sq_z;
		logic             root_step;
		logic             rot_init;
		logic             rot_step;
		logic             round;
		logic             finish;
		logic [CNT_W-1:0] iter;
	} apt_cmd_t;

	// atan(2^-i) in degrees times 65536, rounded.
	function automatic logic signed [ZACC_W-1:0] atan_deg(input logic [CNT_W-1:0] i);
		logic signed [ZACC_W-1:0] v;
		begin
			case (i)
				5'd0:    v = 25'sd2949120;
				5'd1:    v = 25'sd1740967;
				5'd2:    v = 25'sd919879;
				5'd3:    v = 25'sd466945;
				5'd4:    v = 25'sd234379;
				5'd5:    v = 25'sd117304;
				5'd6:    v = 25'sd58666;
				5'd7:    v = 25'sd29335;
				5'd8:    v = 25'sd14668;
				5'd9:    v = 25'sd7334;
				5'd10:   v = 25'sd3667;
				5'd11:   v = 25'sd1833;
				5'd12:   v = 25'sd917;
				5'd13:   v = 25'sd458;
				5'd14:   v = 25'sd229;
				5'd15:   v = 25'sd115;
				5'd16:   v = 25'sd57;
				5'd17:   v = 25'sd29;
				5'd18:   v = 25'sd14;
				5'd19:   v = 25'sd7;
				5'd20:   v = 25'sd4;
				5'd21:   v = 25'sd2;
				5'd22:   v = 25'sd1;
				default: v = 25'sd0;
			endcase
			return v;
		end
	endfunction

endpackage

`default_nettype wire

// File: hdl/apt_regs.sv
`default_nettype none

module apt_regs (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      psel,
	input  wire logic                                      penable,
	input  wire logic                                      pwrite,
	input  wire logic [apt_pkg::ADDR_W-1:0]                paddr,
	input  wire logic [apt_pkg::DATA_W-1:0]                pwdata,
	output logic      [apt_pkg::DATA_W-1:0]                prdata,
	output logic                                           pready,
	output logic signed [apt_pkg::ANGLE_W-1:0]             upper,
	output logic signed [apt_pkg::ANGLE_W-1:0]             lower
);

	logic signed [apt_pkg::ANGLE_W-1:0] upper_q;
	logic signed [apt_pkg::ANGLE_W-1:0] lower_q;
	logic                               wr_en;
	logic signed [apt_pkg::ANGLE_W-1:0] rd_val;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= apt_pkg::UPPER_RESET;
			lower_q <= apt_pkg::LOWER_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				apt_pkg::REG_UPPER: upper_q <= pwdata[apt_pkg::ANGLE_W-1:0];
				apt_pkg::REG_LOWER: lower_q <= pwdata[apt_pkg::ANGLE_W-1:0];
				default:            upper_q <= upper_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			apt_pkg::REG_UPPER: rd_val = upper_q;
			apt_pkg::REG_LOWER: rd_val = lower_q;
			default:            rd_val = upper_q;
		endcase
	end

	// Read data is the register sign-extended to the bus width.
	assign prdata = {{(apt_pkg::DATA_W-apt_pkg::ANGLE_W){rd_val[apt_pkg::ANGLE_W-1]}}, rd_val};
	assign upper  = upper_q;
	assign lower  = lower_q;

endmodule

`default_nettype wire

// File: hdl/apt_dp.sv
`default_nettype none

module apt_dp (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire apt_pkg::apt_cmd_t                    cmd,
	input  wire logic                                 req_type,
	input  wire logic signed [apt_pkg::ACC_W-1:0]     acc_x,
	input  wire logic signed [apt_pkg::ACC_W-1:0]     acc_y,
	input  wire logic signed [apt_pkg::ACC_W-1:0]     acc_z,
	input  wire logic signed [apt_pkg::ANGLE_W-1:0]   upper_threshold,
	input  wire logic signed [apt_pkg::ANGLE_W-1:0]   lower_threshold,
	output logic signed [apt_pkg::ANGLE_W-1:0]        angle,
	output apt_pkg::zone_t                            zone
);

	localparam int unsigned AW = apt_pkg::ACC_W;
	localparam int unsigned VW = apt_pkg::VEC_W;
	localparam int unsigned ZW = apt_pkg::ZACC_W;
	localparam int unsigned PW = apt_pkg::PITCH_W;
	localparam int unsigned NW = apt_pkg::ANGLE_W;

	localparam logic signed [ZW-1:0] RND_HALF = 25'sd128;
	localparam logic signed [ZW-1:0] LIM_HI   =
		{{(ZW-PW){apt_pkg::PITCH_LIMIT[PW-1]}}, apt_pkg::PITCH_LIMIT};
	localparam logic signed [ZW-1:0] LIM_LO   = -LIM_HI;

	// Captured sample.
	logic                               req_q;
	logic signed [AW-1:0]               ax_q;
	logic signed [AW-1:0]               ay_q;
	logic signed [AW-1:0]               az_q;

	// Sum of squares and square root state.
	logic        [apt_pkg::SQ_W-1:0]    sq_q;
	logic        [apt_pkg::SQ_W-1:0]    rad_q;
	logic        [apt_pkg::ROOT_W-1:0]  root_q;
	logic        [apt_pkg::REM_W-1:0]   rem_q;

	// CORDIC vector and angle accumulator.
	logic signed [VW-1:0]               cx_q;
	logic signed [VW-1:0]               cy_q;
	logic signed [ZW-1:0]               cz_q;

	logic signed [PW-1:0]               pitch_q;
	logic signed [PW-1:0]               offset_q;
	logic signed [NW-1:0]               angle_q;
	apt_pkg::zone_t                     zone_q;

	logic signed [AW-1:0]               mul_op;
	logic signed [2*AW-1:0]             prod;
	logic        [apt_pkg::SQ_W-1:0]    sq_sum;
	logic        [apt_pkg::REM_W-1:0]   rem_sh;
	logic        [apt_pkg::REM_W-1:0]   trial;
	logic                               root_ge;
	logic signed [VW-1:0]               dx;
	logic signed [VW-1:0]               dy;
	logic signed [ZW-1:0]               step_ang;
	logic signed [ZW-1:0]               z_sum;
	logic signed [ZW-1:0]               z_rnd;
	logic signed [PW-1:0]               pitch_n;
	logic signed [NW-1:0]               pitch_ext;
	logic signed [NW-1:0]               offset_ext;
	logic signed [NW-1:0]               rel_angle;

	// One shared multiplier squares Y, then Z.
	assign mul_op = cmd.sq_y ? ay_q : az_q;
	assign prod   = mul_op * mul_op;
	assign sq_sum = sq_q + prod;

	// Restoring square root, one result bit per step.
	assign rem_sh  = {rem_q[apt_pkg::REM_W-3:0], rad_q[apt_pkg::SQ_W-1 -: 2]};
	assign trial   = {{(apt_pkg::REM_W-apt_pkg::ROOT_W-2){1'b0}}, root_q, 2'b01};
	assign root_ge = rem_sh >= trial;

	assign dx       = cy_q >>> cmd.iter;
	assign dy       = cx_q >>> cmd.iter;
	assign step_ang = apt_pkg::atan_deg(cmd.iter);

	// Round half up to degrees times 256.
	assign z_sum = cz_q + RND_HALF;
	assign z_rnd = z_sum >>> 8;

	always_comb begin
		priority if (ax_q == '0) begin
			pitch_n = '0;
		end else if (sq_q == '0) begin
			pitch_n = ax_q[AW-1] ? -apt_pkg::PITCH_LIMIT : apt_pkg::PITCH_LIMIT;
		end else if (z_rnd > LIM_HI) begin
			pitch_n = apt_pkg::PITCH_LIMIT;
		end else if (z_rnd < LIM_LO) begin
			pitch_n = -apt_pkg::PITCH_LIMIT;
		end else begin
			pitch_n = z_rnd[PW-1:0];
		end
	end

	assign pitch_ext  = {pitch_q[PW-1], pitch_q};
	assign offset_ext = {offset_q[PW-1], offset_q};
	assign rel_angle  = pitch_ext - offset_ext;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			ax_q  <= acc_x;
			ay_q  <= acc_y;
			az_q  <= acc_z;
		end
		if (cmd.sq_y) begin
			sq_q <= prod;
		end
		if (cmd.sq_z) begin
			sq_q   <= sq_sum;
			rad_q  <= sq_sum;
			root_q <= '0;
			rem_q  <= '0;
		end
		if (cmd.root_step) begin
			rad_q  <= {rad_q[apt_pkg::SQ_W-3:0], 2'b00};
			root_q <= {root_q[apt_pkg::ROOT_W-2:0], root_ge};
			rem_q  <= root_ge ? rem_sh - trial : rem_sh;
		end
		if (cmd.rot_init) begin
			cx_q <= {{(VW-apt_pkg::ROOT_W){1'b0}}, root_q};
			cy_q <= {{(VW-AW-apt_pkg::FRAC_W){ax_q[AW-1]}}, ax_q, {apt_pkg::FRAC_W{1'b0}}};
			cz_q <= '0;
		end
		if (cmd.rot_step) begin
			// A residual of zero counts as non-negative.
			if (!cy_q[VW-1]) begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				cz_q <= cz_q + step_ang;
			end else begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				cz_q <= cz_q - step_ang;
			end
		end
		if (cmd.round) begin
			pitch_q <= pitch_n;
		end
		if (cmd.finish) begin
			if (req_q == apt_pkg::REQ_CAL) begin
				angle_q <= pitch_ext;
				zone_q  <= apt_pkg::ZONE_LEVEL;
			end else begin
				angle_q <= rel_angle;
				// Upper is tested first, so an inverted pair reports tilt-up when both hold.
				priority if (rel_angle > upper_threshold) begin
					zone_q <= apt_pkg::ZONE_UP;
				end else if (rel_angle < lower_threshold) begin
					zone_q <= apt_pkg::ZONE_DOWN;
				end else begin
					zone_q <= apt_pkg::ZONE_LEVEL;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cmd.finish && req_q == apt_pkg::REQ_CAL) begin
			offset_q <= pitch_q;
		end
	end

	assign angle = angle_q;
	assign zone  = zone_q;

endmodule

`default_nettype wire

// File: hdl/apt_ctrl.sv
`default_nettype none

`include "accel_pitch_tilt_detector_assert.svh"

module apt_ctrl #(
	parameter int unsigned CORDIC_STEPS = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output apt_pkg::apt_cmd_t  cmd
);

	localparam int unsigned ROT_STEPS = (CORDIC_STEPS < apt_pkg::ATAN_ENTRIES) ?
		CORDIC_STEPS : apt_pkg::ATAN_ENTRIES;
	localparam logic [apt_pkg::CNT_W-1:0] ROT_LAST  = apt_pkg::CNT_W'(ROT_STEPS - 1);
	localparam logic [apt_pkg::CNT_W-1:0] ROOT_LAST =
		apt_pkg::CNT_W'(apt_pkg::ROOT_STEPS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ_Y,
		ST_SQ_Z,
		ST_ROOT,
		ST_INIT,
		ST_ROT,
		ST_RND,
		ST_DONE
	} state_t;

	state_t                     state_q;
	logic [apt_pkg::CNT_W-1:0]  cnt_q;
	logic                       m_valid_q;
	logic                       out_free;

	assign out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_SQ_Y;
					end
				end
				ST_SQ_Y: begin
					state_q <= ST_SQ_Z;
				end
				ST_SQ_Z: begin
					cnt_q   <= '0;
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ROOT_LAST) begin
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					cnt_q   <= '0;
					state_q <= ST_ROT;
				end
				ST_ROT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ROT_LAST) begin
						state_q <= ST_RND;
					end
				end
				ST_RND: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd      = '0;
		cmd.iter = cnt_q;
		unique case (state_q)
			ST_IDLE: cmd.load      = s_tvalid;
			ST_SQ_Y: cmd.sq_y      = 1'b1;
			ST_SQ_Z: cmd.sq_z      = 1'b1;
			ST_ROOT: cmd.root_step = 1'b1;
			ST_INIT: cmd.rot_init  = 1'b1;
			ST_ROT:  cmd.rot_step  = 1'b1;
			ST_RND:  cmd.round     = 1'b1;
			ST_DONE: cmd.finish    = out_free;
			default: cmd.load      = 1'b0;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;

	`APT_ASSERT_NEXT(a_accept_starts, s_tvalid && s_tready, state_q == ST_SQ_Y, "accepted word did not start the square step")
	`APT_ASSERT_NOW(a_finish_slot_free, cmd.finish, !m_valid_q || m_tready, "result written over an untaken word")
	`APT_ASSERT_NEXT(a_finish_shows, cmd.finish, m_tvalid && state_q == ST_IDLE, "finished result not presented")
	`APT_ASSERT_NOW(a_rot_in_range, state_q == ST_ROT, cnt_q <= ROT_LAST, "rotation index past the table")

endmodule

`default_nettype wire

// File: hdl/accel_pitch_tilt_detector.sv
// Accelerometer pitch-tilt detector. Each input word carries one three-axis sample and a request
// kind; the block returns one word with the pitch angle atan2(X, sqrt(Y*Y+Z*Z)) in degrees times
// 256, clamped to +/-90 degrees, and a zone code. A calibrate request stores the absolute pitch
// as the zero offset and returns it with zone level; a measure request returns pitch minus the
// stored offset and reports tilt-up when that is strictly above the upper threshold, else
// tilt-down when strictly below the lower threshold, else level. A sample with X equal to zero
// gives zero; a sample with only X nonzero gives exactly plus or minus 90 degrees. The block
// works on one word at a time and takes no new word until the last result has entered the
// output register. It loads the sample, squares Y and Z in turn on one shared multiplier,
// takes the square root of the sum in 32 steps at one result bit per cycle, runs the CORDIC
// rotation at one iteration per cycle, then rounds and classifies. The result sits in an
// output register, so a word that waits to be taken does not hold up the computation of the
// next one; only a second finished result waits for it. The user must write the two thresholds
// over the register port only while the block is idle; the block does not enforce this. Upper
// is at address 0 and lower at address 4, as signed 17-bit values in degrees times 256.

`default_nettype none

module accel_pitch_tilt_detector #(
	parameter int unsigned CORDIC_STEPS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Sample input.
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [47:0]                   s_tdata,  // acc_x[15:0], acc_y[31:16], acc_z[47:32]
	input  wire logic                          s_tuser,  // req_type[0]
	// Result output.
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [23:0]                        m_tdata,  // angle[16:0], zone[18:17], zeros above
	// Register port.
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [apt_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [apt_pkg::DATA_W-1:0]    pwdata,
	output logic      [apt_pkg::DATA_W-1:0]    prdata,
	output logic                               pready
);

	apt_pkg::apt_cmd_t                       cmd;
	logic signed [apt_pkg::ANGLE_W-1:0]      upper_threshold;
	logic signed [apt_pkg::ANGLE_W-1:0]      lower_threshold;
	logic signed [apt_pkg::ANGLE_W-1:0]      angle;
	apt_pkg::zone_t                          zone;

	apt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.upper   (upper_threshold),
		.lower   (lower_threshold)
	);

	// Sequencer: square, root, rotate, round, then hand the result to the output register.
	apt_ctrl #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// Datapath: multiplier, square root, CORDIC vectoring, offset and threshold compare.
	apt_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.req_type        (s_tuser),
		.acc_x           (s_tdata[15:0]),
		.acc_y           (s_tdata[31:16]),
		.acc_z           (s_tdata[47:32]),
		.upper_threshold (upper_threshold),
		.lower_threshold (lower_threshold),
		.angle           (angle),
		.zone            (zone)
	);

	assign m_tdata = {5'b0, zone, angle};

endmodule

`default_nettype wire

// File: tb/accel_pitch_tilt_detector_tb.sv
`timescale 1ns / 100ps

module accel_pitch_tilt_detector_tb;

	localparam int CORDIC_STEPS = 16;
	// Cycles without any accepted word, while work is outstanding, before the run is abandoned.
	localparam int STALL_LIMIT  = 5000;
	// Length of the long receiver hold.
	localparam int LONG_HOLD    = 600;

	// One accelerometer sample with its request kind.
	typedef struct {
		logic               req;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
	} sample_t;

	// One predicted result word.
	typedef struct {
		logic signed [apt_pkg::ANGLE_W-1:0] angle;
		apt_pkg::zone_t                     zone;
	} tilt_t;

	// atan(2^-i) in degrees times 65536, rounded.
	localparam longint ATAN_TAB [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	logic                           clk;
	logic                           arst_n   = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [47:0]                    s_tdata  = '0;  // acc_x[15:0], acc_y[31:16], acc_z[47:32]
	logic                           s_tuser  = 1'b0;  // req_type[0]
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [23:0]                    m_tdata;  // angle[16:0], zone[18:17], zeros above
	logic                           psel     = 1'b0;
	logic                           penable  = 1'b0;
	logic                           pwrite   = 1'b0;
	logic [apt_pkg::ADDR_W-1:0]     paddr    = '0;
	logic [apt_pkg::DATA_W-1:0]     pwdata   = '0;
	logic [apt_pkg::DATA_W-1:0]     prdata;
	logic                           pready;

	// Samples waiting to be driven, and results waiting to be seen, oldest first.
	sample_t sample_q[$];
	tilt_t   tilt_q[$];

	// Mirror of the block's registers and its stored zero offset.
	int                 upper_thr = 11520;
	int                 lower_thr = -7680;
	logic signed [15:0] offset_deg = '0;

	// When set, neither side idles.
	logic    quiet = 1'b0;
	int      fail_count = 0;

	accel_pitch_tilt_detector #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Pitch of a sample in degrees times 256: the square root of Y*Y+Z*Z is taken bit by bit
	// at 16 fraction bits, then a CORDIC vectoring pass drives X to zero and sums the angles.
	function automatic logic signed [15:0] compute_pitch(input logic signed [15:0] ax,
			input logic signed [15:0] ay, input logic signed [15:0] az);
		longint unsigned sq, rem, root, bitv;
		longint          xv, yv, zv, dx, dy, r;
		int              i;
		sq = longint'(ay) * longint'(ay) + longint'(az) * longint'(az);
		if (ax == 0)
			return '0;
		if (sq == 0)
			return (ax > 0) ? 16'sd23040 : -16'sd23040;
		rem  = sq << 32;
		root = 0;
		bitv = 64'h4000_0000_0000_0000;
		while (bitv > rem)
			bitv >>= 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem  -= root + bitv;
				root  = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		xv = longint'(root);
		yv = longint'(ax) * 65536;
		zv = 0;
		for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			// Arithmetic shifts round toward minus infinity; a residual of zero counts as positive.
			dx = yv >>> i;
			dy = xv >>> i;
			if (yv >= 0) begin
				xv += dx;
				yv -= dy;
				zv += ATAN_TAB[i];
			end else begin
				xv -= dx;
				yv += dy;
				zv -= ATAN_TAB[i];
			end
		end
		r = (zv + 128) >>> 8;
		if (r > 23040)
			r = 23040;
		if (r < -23040)
			r = -23040;
		return 16'(r);
	endfunction

	// Works out the result of an accepted sample and updates the stored offset on calibrate.
	task automatic queue_tilt(input sample_t smp);
		tilt_t res;
		int    pitch, diff;
		pitch = int'(compute_pitch(smp.ax, smp.ay, smp.az));
		res.zone = apt_pkg::ZONE_LEVEL;
		if (smp.req == apt_pkg::REQ_CAL) begin
			offset_deg = 16'(pitch);
			diff       = pitch;
		end else begin
			diff = pitch - int'(offset_deg);
			// Upper is tested first, so an inverted pair reports tilt-up when both hold.
			if (diff > upper_thr)
				res.zone = apt_pkg::ZONE_UP;
			else if (diff < lower_thr)
				res.zone = apt_pkg::ZONE_DOWN;
		end
		res.angle = apt_pkg::ANGLE_W'(diff);
		tilt_q.push_back(res);
	endtask

	// Axis value: mostly uniform, with corners and small magnitudes mixed in.
	function automatic logic signed [15:0] rand_axis();
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0: begin
				case ($urandom_range(0, 4))
					0: return 16'sd0;
					1: return 16'sd1;
					2: return -16'sd1;
					3: return 16'sh7fff;
					default: return 16'sh8000;
				endcase
			end
			1, 2: return 16'($signed($urandom_range(0, 128)) - 64);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic sample_t rand_sample();
		sample_t smp;
		smp.req = ($urandom_range(0, 7) == 0) ? apt_pkg::REQ_CAL : apt_pkg::REQ_MEAS;
		smp.ax  = rand_axis();
		smp.ay  = rand_axis();
		smp.az  = rand_axis();
		// Now and then the special geometries: only X nonzero, or X zero.
		case ($urandom_range(0, 11))
			0: begin
				smp.ay = '0;
				smp.az = '0;
			end
			1: smp.ax = '0;
			default: ;
		endcase
		return smp;
	endfunction

	task automatic push_sample(input logic req, input int ax, input int ay, input int az);
		sample_t smp;
		smp.req = req;
		smp.ax  = 16'(ax);
		smp.ay  = 16'(ay);
		smp.az  = 16'(az);
		sample_q.push_back(smp);
	endtask

	// Returns once every queued sample has been taken and every result has come back.
	task automatic wait_idle();
		@(negedge clk);
		while (sample_q.size() != 0 || s_tvalid || tilt_q.size() != 0)
			@(negedge clk);
	endtask

	// Register write followed by a read-back of the same register.
	task automatic write_threshold(input logic idx, input int value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= apt_pkg::DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == apt_pkg::REG_UPPER)
			upper_thr = value;
		else
			lower_thr = value;
		@(posedge clk);
		psel    <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[apt_pkg::ANGLE_W-1:0] !== apt_pkg::ANGLE_W'(value)) begin
			$display("%0t: register %0d read back, expected %0d, got %0d", $time, idx,
				value, $signed(prdata[apt_pkg::ANGLE_W-1:0]));
			fail_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// One phase of the run: new thresholds while idle, then random samples.
	task automatic run_phase(input int upper, input int lower, input int count,
			input logic no_idle);
		int n;
		wait_idle();
		write_threshold(apt_pkg::REG_UPPER, upper);
		write_threshold(apt_pkg::REG_LOWER, lower);
		@(negedge clk);
		quiet = no_idle;
		for (n = 0; n < count; n++)
			sample_q.push_back(rand_sample());
	endtask

	// Sender: takes samples from the queue and offers them in bursts of random length with random
	// gaps between them. A sample stays on the bus until it is accepted, and the result it will
	// produce is predicted at the edge where it is accepted.
	sample_t on_bus;
	int      burst_left = 0;
	int      gap_left   = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				queue_tilt(on_bus);
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0 && !quiet) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (sample_q.size() > 0) begin
					on_bus    = sample_q.pop_front();
					s_tdata  <= {on_bus.az, on_bus.ay, on_bus.ax};
					s_tuser  <= on_bus.req;
					s_tvalid <= 1'b1;
					gap_left  = 0;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 7);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: ready follows a 16-bit pattern that is drawn afresh each time it runs out.
	// Twice in the run it holds off for a long stretch, counted here, so that the output
	// register fills, the next result finishes behind it and the block stops taking samples.
	int          taken_cnt = 0;
	int          hold_left = 0;
	logic [15:0] stall_pat = 16'hffff;
	logic [3:0]  pat_pos   = '0;

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				taken_cnt++;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (m_tvalid && m_tready && (taken_cnt == 300 || taken_cnt == 900)) begin
				hold_left = LONG_HOLD - 1;
				m_tready <= 1'b0;
			end else if (quiet) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= stall_pat[pat_pos];
				pat_pos++;
				if (pat_pos == 0) begin
					case ($urandom_range(0, 3))
						0: stall_pat = 16'hffff;
						1: stall_pat = 16'($urandom);
						default: stall_pat = 16'($urandom | $urandom);
					endcase
				end
			end
		end
	end

	// Checker: every accepted result word is compared with the oldest prediction.
	tilt_t want;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (tilt_q.size() == 0) begin
				$display("%0t: result word with none expected, angle %0d zone %0d", $time,
					$signed(m_tdata[16:0]), m_tdata[18:17]);
				fail_count++;
			end else begin
				want = tilt_q.pop_front();
				if (m_tdata[16:0] !== want.angle) begin
					$display("%0t: angle mismatch, expected %0d, got %0d", $time, want.angle,
						$signed(m_tdata[16:0]));
					fail_count++;
				end
				if (m_tdata[18:17] !== want.zone) begin
					$display("%0t: zone mismatch, expected %0d, got %0d", $time, want.zone,
						m_tdata[18:17]);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: counts cycles in which no word moves on either side while work is outstanding.
	int stall_cnt = 0;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(sample_q.size() == 0 && !s_tvalid && tilt_q.size() == 0))
			stall_cnt = 0;
		else
			stall_cnt++;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset thresholds (45 and -30 degrees). Zero input, the axis-only cases at both
		// extremes, full-scale magnitudes, and a calibrate at -90 that pushes the difference
		// to the widest angle the output can carry.
		push_sample(apt_pkg::REQ_MEAS, 0, 0, 0);
		push_sample(apt_pkg::REQ_CAL, 0, 0, 0);
		push_sample(apt_pkg::REQ_MEAS, 32767, 0, 0);
		push_sample(apt_pkg::REQ_MEAS, -32768, 0, 0);
		push_sample(apt_pkg::REQ_MEAS, 0, 32767, -32768);
		push_sample(apt_pkg::REQ_MEAS, 1, 0, -32768);
		push_sample(apt_pkg::REQ_MEAS, -1, 32767, 0);
		push_sample(apt_pkg::REQ_MEAS, 32767, 32767, 32767);
		push_sample(apt_pkg::REQ_MEAS, -32768, -32768, -32768);
		push_sample(apt_pkg::REQ_MEAS, 32767, -32768, 0);
		push_sample(apt_pkg::REQ_MEAS, 100, 100, 0);
		push_sample(apt_pkg::REQ_CAL, -32768, 0, 0);
		push_sample(apt_pkg::REQ_MEAS, 32767, 0, 0);
		push_sample(apt_pkg::REQ_MEAS, -32768, 1, 1);
		push_sample(apt_pkg::REQ_CAL, 0, 5, 5);
		push_sample(apt_pkg::REQ_MEAS, -5000, 3000, -4000);

		// Thresholds at exactly +/-90 degrees: the clamped angles equal them and stay level.
		run_phase(23040, -23040, 0, 1'b0);
		push_sample(apt_pkg::REQ_MEAS, 1000, 0, 0);
		push_sample(apt_pkg::REQ_MEAS, -1000, 0, 0);
		push_sample(apt_pkg::REQ_MEAS, 20000, 1, 0);

		// Inverted pair: zero lies above upper and below lower, tilt-up wins.
		run_phase(-1000, 1000, 0, 1'b0);
		push_sample(apt_pkg::REQ_MEAS, 0, 0, 0);
		push_sample(apt_pkg::REQ_MEAS, -32768, 0, 0);
		push_sample(apt_pkg::REQ_MEAS, 32767, 0, 0);

		// Random phases over the threshold extremes and a few drawn values; the first runs
		// without any idling on either side.
		run_phase(46080, -46080, 200, 1'b1);
		run_phase(-46080, 46080, 200, 1'b0);
		run_phase(0, 0, 200, 1'b0);
		run_phase(11520, -7680, 200, 1'b0);
		run_phase($urandom_range(0, 92160) - 46080, $urandom_range(0, 92160) - 46080, 210,
			1'b0);
		run_phase($urandom_range(0, 20000) - 10000, $urandom_range(0, 20000) - 10000, 210,
			1'b0);

		wait_idle();
		repeat (CORDIC_STEPS + 40) @(negedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: files.f
+incdir+hdl
hdl/apt_pkg.sv
hdl/apt_regs.sv
hdl/apt_dp.sv
hdl/apt_ctrl.sv
hdl/accel_pitch_tilt_detector.sv
tb/accel_pitch_tilt_detector_tb.sv
